// ----- sv/tcm_pkg.sv -----
// Shared types, constants and register codes of the terrace curve mapper.
package tcm_pkg;

	localparam int MAX_POINTS_DEF = 8;
	localparam int FRAC_BITS_DEF  = 12;
	localparam int SAMPLE_W       = 16;
	localparam int CFG_DATA_W     = 64;
	localparam int CFG_ADDR_W     = 5;
	localparam int COUNT_W        = 4;
	localparam int REGS_PER_WORD  = 4;

	typedef logic signed [SAMPLE_W-1:0] q312_t;

	typedef enum logic [1:0] {
		REG_POINT_COUNT = 2'd0,
		REG_POINTS_LO   = 2'd1,
		REG_POINTS_HI   = 2'd2,
		REG_INVERT      = 2'd3
	} reg_idx_t;

endpackage

// ----- sv/tcm_sample_if.sv -----
// Sample request channel of the terrace curve mapper.
interface tcm_sample_if import tcm_pkg::*;;
	logic  valid;
	logic  ready;
	q312_t sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink (input valid, input sample_value, output ready);
endinterface

// ----- sv/tcm_result_if.sv -----
// Result request channel of the terrace curve mapper.
interface tcm_result_if import tcm_pkg::*;;
	logic  valid;
	logic  ready;
	q312_t mapped_value;

	modport source (output valid, output mapped_value, input ready);
	modport sink (input valid, input mapped_value, output ready);
endinterface

// ----- sv/terrace_curve_mapper_unit.sv -----
// Top level of the terrace curve mapper: config registers and the mapping pipeline.
//
// Usage: a signed Q3.12 request enters on the sample channel (valid/ready) and
// one Q3.12 result leaves on the result channel for each request, in order.
// Control points, their count and the invert flag are written over the APB
// port while no request is in flight; reads return the register values.
// The pipeline holds FRAC_BITS + 5 register stages: segment search, offset
// subtract, one restoring divider stage per fraction bit of alpha, invert and
// square, scale multiply, final add. One request per cycle is taken and
// delivered while the result receiver takes results; the divider depth sets the
// latency. Each stage advances when its successor is empty or advancing, so
// a stalled receiver holds all data in place, bubbles close up, and sample
// ready drops only once every stage is full.
// Reset clears all config registers (count 0, points 0, no invert) and all stage
// valid bits; nothing is in flight after reset.
module terrace_curve_mapper_unit
	import tcm_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tcm_sample_if.sink            sample,
	tcm_result_if.source          result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int IW = $clog2(MAX_POINTS);
	localparam int AW = FRAC_BITS + 1;
	localparam int SW = 2 * FRAC_BITS + 2;
	localparam int DW = SAMPLE_W + 1;
	localparam int PW = DW + SW + 1;

	// Configuration registers
	logic [COUNT_W-1:0]    point_count_q;
	logic [CFG_DATA_W-1:0] points_lo_q;
	logic [CFG_DATA_W-1:0] points_hi_q;
	logic                  invert_q;
	reg_idx_t              reg_idx;

	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
			points_lo_q   <= '0;
			points_hi_q   <= '0;
			invert_q      <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_POINT_COUNT: point_count_q <= pwdata[COUNT_W-1:0];
				REG_POINTS_LO:   points_lo_q   <= pwdata;
				REG_POINTS_HI:   points_hi_q   <= pwdata;
				REG_INVERT:      invert_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_POINT_COUNT: prdata = CFG_DATA_W'(point_count_q);
			REG_POINTS_LO:   prdata = points_lo_q;
			REG_POINTS_HI:   prdata = points_hi_q;
			REG_INVERT:      prdata = CFG_DATA_W'(invert_q);
			default:         prdata = '0;
		endcase
	end

	// Stage enables, from the output back to the input
	logic en_s1, en_s2, en_s4, en_s5, en_s6;
	logic en_s3 [FRAC_BITS];

	logic vld_s1, vld_s2, vld_s4, vld_s5, vld_s6;
	logic vld_s3 [FRAC_BITS];

	assign en_s6 = !vld_s6 || result.ready;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_en
		if (k == FRAC_BITS - 1) begin : g_last
			assign en_s3[k] = !vld_s3[k] || en_s4;
		end else begin : g_mid
			assign en_s3[k] = !vld_s3[k] || en_s3[k+1];
		end
	end

	assign en_s2        = !vld_s2 || en_s3[0];
	assign en_s1        = !vld_s1 || en_s2;
	assign sample.ready = en_s1;

	// Stage 1: segment search
	q312_t           pts [MAX_POINTS];
	logic [CW-1:0]   n_c;
	logic [CW-1:0]   idx_c;
	logic [CW-1:0]   lo_c;
	q312_t           a_c, b_c, v_c;
	q312_t           a_s1, b_s1, v_s1;

	always_comb begin
		for (int i = 0; i < MAX_POINTS; i++) begin
			if (i < REGS_PER_WORD) begin
				pts[i] = q312_t'(points_lo_q[SAMPLE_W*i +: SAMPLE_W]);
			end else begin
				pts[i] = q312_t'(points_hi_q[SAMPLE_W*(i-REGS_PER_WORD) +: SAMPLE_W]);
			end
		end
	end

	always_comb begin
		if (point_count_q > COUNT_W'(MAX_POINTS)) begin
			n_c = CW'(MAX_POINTS);
		end else begin
			n_c = CW'(point_count_q);
		end
		idx_c = n_c;
		for (int i = MAX_POINTS - 1; i >= 0; i--) begin
			if (CW'(i) < n_c && sample.sample_value < pts[i]) begin
				idx_c = CW'(i);
			end
		end
		lo_c = idx_c - CW'(1);
		if (n_c == '0) begin
			a_c = '0;
			b_c = '0;
			v_c = '0;
		end else if (idx_c == '0) begin
			a_c = pts[0];
			b_c = pts[0];
			v_c = pts[0];
		end else if (idx_c == n_c) begin
			a_c = pts[lo_c[IW-1:0]];
			b_c = pts[lo_c[IW-1:0]];
			v_c = pts[lo_c[IW-1:0]];
		end else begin
			a_c = pts[lo_c[IW-1:0]];
			b_c = pts[idx_c[IW-1:0]];
			v_c = sample.sample_value;
		end
	end

	// Stage 2: offset and span
	q312_t                a_s2;
	logic [SAMPLE_W-1:0]  num_s2, den_s2;
	logic [DW-1:0]        num_c, den_c;

	assign num_c = DW'(v_s1) - DW'(a_s1);
	assign den_c = DW'(b_s1) - DW'(a_s1);

	// Stage 3: restoring division, one quotient bit per stage
	q312_t                a_s3   [FRAC_BITS];
	logic [SAMPLE_W-1:0]  rem_s3 [FRAC_BITS];
	logic [SAMPLE_W-1:0]  den_s3 [FRAC_BITS];
	logic [FRAC_BITS-1:0] quo_s3 [FRAC_BITS];

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
		q312_t                a_in;
		logic [SAMPLE_W-1:0]  rem_in, den_in;
		logic [FRAC_BITS-1:0] quo_in;
		logic                 vld_in;
		logic [SAMPLE_W:0]    trial;
		logic                 fit;

		if (k == 0) begin : g_first
			assign a_in   = a_s2;
			assign rem_in = num_s2;
			assign den_in = den_s2;
			assign quo_in = '0;
			assign vld_in = vld_s2;
		end else begin : g_next
			assign a_in   = a_s3[k-1];
			assign rem_in = rem_s3[k-1];
			assign den_in = den_s3[k-1];
			assign quo_in = quo_s3[k-1];
			assign vld_in = vld_s3[k-1];
		end

		assign trial = {rem_in, 1'b0};
		assign fit   = trial >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s3[k] <= 1'b0;
			end else if (en_s3[k]) begin
				vld_s3[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en_s3[k]) begin
				a_s3[k]   <= a_in;
				den_s3[k] <= den_in;
				quo_s3[k] <= {quo_in[FRAC_BITS-2:0], fit};
				if (fit) begin
					rem_s3[k] <= SAMPLE_W'(trial - {1'b0, den_in});
				end else begin
					rem_s3[k] <= trial[SAMPLE_W-1:0];
				end
			end
		end
	end

	// Stage 4: invert and square
	logic [AW-1:0]        alpha_c;
	q312_t                a4_c;
	logic signed [DW-1:0] diff_c;
	q312_t                a_s4;
	logic signed [DW-1:0] diff_s4;
	logic [SW-1:0]        asq_s4;

	always_comb begin
		if (invert_q) begin
			alpha_c = (AW'(1) << FRAC_BITS) - AW'(quo_s3[FRAC_BITS-1]);
			a4_c    = q312_t'(a_s3[FRAC_BITS-1] + den_s3[FRAC_BITS-1]);
			diff_c  = -$signed({1'b0, den_s3[FRAC_BITS-1]});
		end else begin
			alpha_c = AW'(quo_s3[FRAC_BITS-1]);
			a4_c    = a_s3[FRAC_BITS-1];
			diff_c  = $signed({1'b0, den_s3[FRAC_BITS-1]});
		end
	end

	// Stage 5: scale the span
	q312_t                a_s5;
	logic signed [PW-1:0] prod_s5;
	logic signed [PW-1:0] prod_c;

	assign prod_c = PW'(diff_s4 * $signed({1'b0, asq_s4}))
		+ (PW'(1) <<< (2 * FRAC_BITS - 1));

	// Stage 6: final add into the output register
	logic signed [PW-1:0] step_c;

	assign step_c = prod_s5 >>> (2 * FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= sample.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s4) vld_s4 <= vld_s3[FRAC_BITS-1];
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			a_s1 <= a_c;
			b_s1 <= b_c;
			v_s1 <= v_c;
		end
		if (en_s2) begin
			a_s2   <= a_s1;
			num_s2 <= num_c[SAMPLE_W-1:0];
			den_s2 <= den_c[SAMPLE_W-1:0];
		end
		if (en_s4) begin
			a_s4    <= a4_c;
			diff_s4 <= diff_c;
			asq_s4  <= SW'(alpha_c * alpha_c);
		end
		if (en_s5) begin
			a_s5    <= a_s4;
			prod_s5 <= prod_c;
		end
		if (en_s6) begin
			result.mapped_value <= a_s5 + q312_t'(step_c[SAMPLE_W-1:0]);
		end
	end

	assign result.valid = vld_s6;

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s6 |-> sample.ready)
		else $error("sample ready low with an empty output stage");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> vld_s1)
		else $error("accepted request lost before stage 1");

	a_offset_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && den_s2 != '0 |-> num_s2 < den_s2)
		else $error("sample outside the selected segment");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3[FRAC_BITS-1] && den_s3[FRAC_BITS-1] != '0
		|-> rem_s3[FRAC_BITS-1] < den_s3[FRAC_BITS-1])
		else $error("divider remainder not below divisor");

endmodule

// ----- tb/sv/terrace_curve_mapper_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the terrace curve mapper: directed and random samples, scored in order.
module terrace_curve_mapper_unit_tb
	import tcm_pkg::*;
;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = FRAC_BITS_DEF + 12;
	localparam int RANDOM_ITEMS = 530;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	tcm_sample_if sample_ch();
	tcm_result_if result_ch();

	terrace_curve_mapper_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic [COUNT_W-1:0] cur_count;
	logic [63:0]        cur_points_lo;
	logic [63:0]        cur_points_hi;
	logic               cur_invert;

	q312_t expected_mapped[$];
	int    mismatches = 0;
	int    cycle_count = 0;
	bit    gapless;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL terrace_curve_mapper_unit");
			$finish;
		end
	end

	function automatic longint point_at(input int i);
		logic [63:0] w;
		q312_t       p;
		w = (i < REGS_PER_WORD) ? cur_points_lo : cur_points_hi;
		p = w[16*(i % REGS_PER_WORD) +: 16];
		return p;
	endfunction

	function automatic q312_t terrace_map(input q312_t v);
		int     n;
		int     idx;
		int     lo;
		int     hi;
		longint a;
		longint b;
		longint t;
		longint num;
		longint den;
		longint alpha;
		longint prod;
		q312_t  res;
		n = (cur_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(cur_count);
		if (n == 0) return '0;
		idx = 0;
		while (idx < n && !(v < point_at(idx))) idx++;
		lo = (idx == 0) ? 0 : idx - 1;
		hi = (idx > n - 1) ? n - 1 : idx;
		if (lo == hi) begin
			res = q312_t'(point_at(hi));
			return res;
		end
		a = point_at(lo);
		b = point_at(hi);
		num = v - a;
		den = b - a;
		alpha = (num <<< FRAC_BITS_DEF) / den;
		if (cur_invert) begin
			alpha = (64'sd1 <<< FRAC_BITS_DEF) - alpha;
			t = a;
			a = b;
			b = t;
		end
		prod = (b - a) * (alpha * alpha) + (64'sd1 <<< (2*FRAC_BITS_DEF - 1));
		res = q312_t'(a + (prod >>> (2*FRAC_BITS_DEF)));
		return res;
	endfunction

	function automatic logic [63:0] pack4(input q312_t p0, input q312_t p1,
			input q312_t p2, input q312_t p3);
		return {p3, p2, p1, p0};
	endfunction

	function automatic int draw_gap();
		return gapless ? 0 : $urandom_range(0, 8);
	endfunction

	always @(posedge clk) begin : score
		q312_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_mapped.size() == 0) begin
				$error("mapped_value: expected none, got %0d", result_ch.mapped_value);
				mismatches++;
			end else begin
				want = expected_mapped.pop_front();
				if (result_ch.mapped_value !== want) begin
					$error("mapped_value: expected %0d, got %0d", want,
						result_ch.mapped_value);
					mismatches++;
				end
			end
		end
	end

	initial begin : drain_results
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
		end
	end

	task automatic send_sample(input q312_t v);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.sample_value <= v;
		do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
		expected_mapped.push_back(terrace_map(v));
	endtask

	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		while (expected_mapped.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t r, input logic [63:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 3'b000};
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (r)
			REG_POINT_COUNT: cur_count = d[COUNT_W-1:0];
			REG_POINTS_LO:   cur_points_lo = d;
			REG_POINTS_HI:   cur_points_hi = d;
			REG_INVERT:      cur_invert = d[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [COUNT_W-1:0] cnt, input logic [63:0] lo_w,
			input logic [63:0] hi_w, input logic inv);
		wait_idle();
		apb_write(REG_POINT_COUNT, 64'(cnt));
		apb_write(REG_POINTS_LO, lo_w);
		apb_write(REG_POINTS_HI, hi_w);
		apb_write(REG_INVERT, 64'(inv));
	endtask

	task automatic pick_points(output logic [63:0] lo_w, output logic [63:0] hi_w);
		q312_t pts[8];
		q312_t t;
		int    kind;
		int    span;
		int    base;
		kind = $urandom_range(0, 3);
		span = (kind == 1) ? $urandom_range(1, 2000) : 65536;
		base = $urandom_range(0, 65535);
		foreach (pts[i]) pts[i] = q312_t'($urandom_range(0, 65535));
		if (kind == 1) begin
			foreach (pts[i]) pts[i] = q312_t'(base) + q312_t'($urandom_range(0, span - 1));
		end
		if (kind != 2) begin
			for (int i = 1; i < 8; i++) begin
				for (int j = i; j > 0 && pts[j] < pts[j-1]; j--) begin
					t = pts[j];
					pts[j] = pts[j-1];
					pts[j-1] = t;
				end
			end
		end
		if (kind == 3) begin
			pts[0] = 16'sh8000;
			pts[7] = 16'sh7fff;
		end
		lo_w = pack4(pts[0], pts[1], pts[2], pts[3]);
		hi_w = pack4(pts[4], pts[5], pts[6], pts[7]);
	endtask

	function automatic q312_t pick_sample();
		q312_t  s;
		int     i;
		longint a;
		longint b;
		i = $urandom_range(0, 7);
		a = point_at(i);
		b = point_at((i + 1) % 8);
		case ($urandom_range(0, 7))
			0: s = q312_t'($urandom_range(0, 65535));
			1: s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			2, 3: s = q312_t'(a + $urandom_range(0, 64) - 32);
			default: s = (b > a) ? q312_t'(a + $urandom_range(0, int'(b - a - 1)))
				: q312_t'(a);
		endcase
		return s;
	endfunction

	task automatic test_zero_count();
		set_config(4'd0, pack4(16'sh1000, 16'sh2000, 16'sh3000, 16'sh4000),
			pack4(16'sh5000, 16'sh6000, 16'sh7000, 16'sh7fff), 1'b1);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_sample(16'sh04d2);
	endtask

	task automatic test_sorted_curve();
		q312_t probes[8];
		probes = '{16'sh8000, 16'shc000, 16'shd000, 16'shdfff,
			16'sh0800, 16'sh3fff, 16'sh4000, 16'sh7fff};
		for (int inv = 0; inv < 2; inv++) begin
			set_config(4'd8, pack4(16'shc000, 16'she000, 16'shf000, 16'sh0000),
				pack4(16'sh1000, 16'sh2000, 16'sh3000, 16'sh4000), inv[0]);
			foreach (probes[i]) send_sample(probes[i]);
		end
	endtask

	task automatic test_full_range_pair();
		set_config(4'd2, pack4(16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000),
			'0, 1'b1);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(16'sh7ffe);
		send_sample(16'sh7fff);
	endtask

	task automatic test_random_phases();
		int          sent;
		int          items;
		logic [3:0]  cnt;
		logic [63:0] lo_w;
		logic [63:0] hi_w;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: cnt = 4'd0;
				1: cnt = 4'd1;
				2: cnt = 4'd2;
				3: cnt = 4'($urandom_range(9, 15));
				4: cnt = 4'd15;
				5, 6: cnt = 4'($urandom_range(3, 7));
				default: cnt = 4'd8;
			endcase
			pick_points(lo_w, hi_w);
			set_config(cnt, lo_w, hi_w, 1'($urandom_range(0, 1)));
			gapless = ($urandom_range(0, 3) == 0);
			items = $urandom_range(20, 48);
			repeat (items) send_sample(pick_sample());
			sent += items;
		end
		gapless = 1'b0;
	endtask

	initial begin
		arst_n                 <= 1'b0;
		psel                   <= 1'b0;
		penable                <= 1'b0;
		pwrite                 <= 1'b0;
		paddr                  <= '0;
		pwdata                 <= '0;
		sample_ch.valid        <= 1'b0;
		sample_ch.sample_value <= '0;
		result_ch.ready        <= 1'b0;
		cur_count     = '0;
		cur_points_lo = '0;
		cur_points_hi = '0;
		cur_invert    = 1'b0;
		gapless       = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_count();
		test_sorted_curve();
		test_full_range_pair();
		test_random_phases();
		wait_idle();
		if (mismatches == 0 && expected_mapped.size() == 0) begin
			$display("PASS terrace_curve_mapper_unit");
		end else begin
			$display("FAIL terrace_curve_mapper_unit");
		end
		$finish;
	end

endmodule
